FILE: rtl/hsrp_pkg.sv
// Package for the hex sensor record parser: character codes, parse phase
// encoding, field widths and the hex digit decoder. No dependencies.
`default_nettype none

package hsrp_pkg;

    localparam int WINDOW_LINES_DEF = 256;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam int         CNT_W     = 6;
    localparam logic [5:0] MAX_CHARS = 6'd40;
    localparam int         ACC_W     = 18;
    localparam int         DATA_W    = 32;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PH_SEARCH  = 4'b0001,
        PH_SKIP    = 4'b0010,
        PH_COLLECT = 4'b0100,
        PH_FULL    = 4'b1000
    } phase_t;

    // Value of one text character as a hex digit; anything that is not a
    // lowercase hex digit decodes as minus one.
    function automatic logic signed [4:0] digit_value(input logic [7:0] c);
        logic signed [4:0] v;
        begin
            v = -5'sd1;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                v = $signed({1'b0, c[3:0]});
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                v = $signed({1'b0, c[3:0]}) + 5'sd9;
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hex_sensor_record_parser.sv
// Hex sensor record parser, top level: parses text lines byte by byte into
// signed 16-bit sensor samples. Depends on hsrp_pkg.
//
//  Channel   Direction  Payload (low bit first)                          Handshake
//  s_axis    in         tdata[7:0] char_in                               tvalid/tready
//  m_axis    out        tdata: channel, sample_value, sample_index, pad  tvalid/tready
//                       tlast: last_of_record
//  cfg       in         cfg_wr_data[1:0] sensor_count                    cfg_wr_en
//
// One byte is accepted per clock cycle, continuously, as long as the output
// side keeps taking results. A byte passes through an input register and a
// result register before its sample appears. The parse state updates in a
// single pass in the stage between the two registers. The output register
// only waits when the downstream side holds tready low; then the input
// register fills and s_axis_tready drops. rst_n clears the parse phase,
// counters and valid flags asynchronously and sets sensor_count to three.
`default_nettype none

module hex_sensor_record_parser #(
    parameter int WINDOW_LINES = hsrp_pkg::WINDOW_LINES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // tdata: [7:0] char_in
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,
    // tdata: [3:0] channel, [19:4] sample_value, [27:20] sample_index, [31:28] zero
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [hsrp_pkg::DATA_W-1:0]     m_axis_tdata,
    output logic                            m_axis_tlast,
    input  wire logic                       cfg_wr_en,
    input  wire logic [1:0]                 cfg_wr_data
);

    localparam int LC_W = (WINDOW_LINES > 1) ? $clog2(WINDOW_LINES) : 1;
    localparam logic [LC_W:0] WIN_LIM = (LC_W + 1)'(WINDOW_LINES);

    // Configuration register.
    logic [1:0] sensor_count_reg;

    // Input register stage.
    logic       in_valid_reg;
    logic [7:0] in_char_reg;

    // Parse state.
    hsrp_pkg::phase_t                    phase_reg, phase_next;
    logic [hsrp_pkg::CNT_W-1:0]          count_reg, count_next;
    logic signed [hsrp_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [LC_W-1:0]                     line_reg, line_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  out_channel_reg, out_channel_next;
    logic [15:0] out_value_reg, out_value_next;
    logic [7:0]  out_index_reg, out_index_next;
    logic        out_last_reg, out_last_next;

    logic advance;
    logic emit;

    // The processing stage moves when the result slot is free or being taken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'b0, out_index_reg, out_value_reg, out_channel_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_count_reg <= 2'd3;
        end
        else if (cfg_wr_en)
        begin
            sensor_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
        end
    end

    // Single-pass parse of the registered character.
    logic                               line_end;
    logic [1:0]                         pos;
    logic signed [4:0]                  digit;
    logic signed [hsrp_pkg::ACC_W-1:0]  term;
    logic signed [hsrp_pkg::ACC_W-1:0]  sum;
    logic [hsrp_pkg::CNT_W-1:0]         count_inc;
    logic [3:0]                         group;
    logic [3:0]                         limit;
    logic [LC_W+7:0]                    line_ext;

    always_comb
    begin
        line_end  = (in_char_reg == hsrp_pkg::CHAR_NL) || (in_char_reg == hsrp_pkg::CHAR_NUL);
        pos       = count_reg[1:0];
        digit     = hsrp_pkg::digit_value(in_char_reg);
        // Nibble weights 16, 1, 4096, 256 for the four positions of a group.
        case (pos)
            2'd0:    term = hsrp_pkg::ACC_W'(digit) <<< 4;
            2'd1:    term = hsrp_pkg::ACC_W'(digit);
            2'd2:    term = hsrp_pkg::ACC_W'(digit) <<< 12;
            default: term = hsrp_pkg::ACC_W'(digit) <<< 8;
        endcase
        sum       = acc_reg + term;
        count_inc = count_reg + 1'b1;
        group     = count_inc[5:2] - 4'd1;
        limit     = {2'b0, sensor_count_reg} + {1'b0, sensor_count_reg, 1'b0};
        line_ext  = {8'b0, line_reg};

        phase_next = phase_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        line_next  = line_reg;
        emit       = 1'b0;

        if (line_end)
        begin
            phase_next = hsrp_pkg::PH_SEARCH;
            count_next = '0;
            acc_next   = '0;
            if (({1'b0, line_reg} + 1'b1) >= WIN_LIM)
            begin
                line_next = '0;
            end
            else
            begin
                line_next = line_reg + 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                hsrp_pkg::PH_SEARCH:
                begin
                    if (in_char_reg == hsrp_pkg::CHAR_COLON)
                    begin
                        phase_next = hsrp_pkg::PH_SKIP;
                    end
                end
                hsrp_pkg::PH_SKIP:
                begin
                    phase_next = hsrp_pkg::PH_COLLECT;
                end
                hsrp_pkg::PH_COLLECT:
                begin
                    if (in_char_reg != hsrp_pkg::CHAR_SPACE)
                    begin
                        count_next = count_inc;
                        if (count_inc >= hsrp_pkg::MAX_CHARS)
                        begin
                            phase_next = hsrp_pkg::PH_FULL;
                        end
                        if (pos != 2'd3)
                        begin
                            acc_next = sum;
                        end
                        else
                        begin
                            acc_next = '0;
                            // Group zero is the timestamp and is dropped.
                            emit = (group >= 4'd1) && (group <= limit);
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // Wrapping above 32767 leaves exactly the low 16 bits of the sum.
        out_valid_next   = emit;
        out_channel_next = group - 4'd1;
        out_value_next   = sum[15:0];
        out_index_next   = line_ext[7:0];
        out_last_next    = (group == limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hsrp_pkg::PH_SEARCH;
            count_reg     <= '0;
            acc_reg       <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && out_valid_next;
            if (in_valid_reg)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                acc_reg   <= acc_next;
                line_reg  <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && out_valid_next)
        begin
            out_channel_reg <= out_channel_next;
            out_value_reg   <= out_value_next;
            out_index_reg   <= out_index_next;
            out_last_reg    <= out_last_next;
        end
    end

    // The character count never passes the line limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hsrp_pkg::MAX_CHARS)
        else $error("character count above limit");

    // The full phase is reached only with the limit collected.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hsrp_pkg::PH_FULL |-> count_reg == hsrp_pkg::MAX_CHARS)
        else $error("full phase with short count");

    // At a group boundary the partial sum has been cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[1:0] == 2'd0 |-> acc_reg == '0)
        else $error("accumulator not cleared at group boundary");

    // Nothing is collected before the colon and skipped character are seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hsrp_pkg::PH_SEARCH || phase_reg == hsrp_pkg::PH_SKIP)
        |-> count_reg == '0)
        else $error("characters counted before collection");

    // A presented result always names one of the nine axes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd8)
        else $error("channel out of range");

endmodule

`default_nettype wire
